// ===== hw/rtl/cmn_pkg.sv =====
// shared types, constants and functions of the cyclotomic minor norm block
// no dependencies; used by every module under hw/rtl
package cmn_pkg;

    localparam int NUM_COEFF   = 32;
    localparam int NUM_FACTOR  = 8;
    localparam int COEF_W      = 11;
    localparam int NORM_W      = 19;
    localparam int IDX_W       = 5;
    localparam int EXP_W       = 6;
    localparam logic [NORM_W-1:0] BUDGET_RESET = 19'd939;
    localparam logic [IDX_W-1:0]  LAST_IDX     = 5'd31;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [NUM_COEFF-1:0][COEF_W-1:0] vec_t;

    localparam vec_t VEC_ONE = vec_t'(1);

    // one binomial zeta^e_var - zeta^e_fix
    typedef struct packed {
        logic [EXP_W-1:0] e_var;
        logic [EXP_W-1:0] e_fix;
    } binom_t;

    // lane x holds P_A(x)P_C(y), lane y holds P_A(y)P_C(x)
    typedef struct packed {
        binom_t [NUM_FACTOR-1:0] lx;
        binom_t [NUM_FACTOR-1:0] ly;
        logic                    ok;
    } ctl_t;

    // coefficient k of zeta^e * v, folded with zeta^32 = -1
    function automatic coef_t rot_coef(vec_t v, logic [EXP_W-1:0] e, logic [IDX_W-1:0] k);
        logic [EXP_W-1:0] d;
        coef_t            t;
        d = {1'b0, k} - e;
        t = v[d[IDX_W-1:0]];
        rot_coef = d[EXP_W-1] ? -t : t;
    endfunction

    // v * (zeta^ep - zeta^en)
    function automatic vec_t binom_mul(vec_t v, logic [EXP_W-1:0] ep, logic [EXP_W-1:0] en);
        vec_t  r;
        coef_t tp;
        coef_t tn;
        for (int k = 0; k < NUM_COEFF; k++) begin
            tp   = rot_coef(v, ep, IDX_W'(k));
            tn   = rot_coef(v, en, IDX_W'(k));
            r[k] = tp - tn;
        end
        return r;
    endfunction

    // membership mask of the coset {j : j == r modulo the step}; lowmask picks the step
    function automatic logic [63:0] coset_member(logic [EXP_W-1:0] r, logic [EXP_W-1:0] lowmask);
        logic [63:0] m;
        for (int j = 0; j < 64; j++) begin
            m[j] = (((EXP_W'(j)) ^ r) & lowmask) == '0;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/cmn_factor_stage.sv =====
// one pipeline stage: multiplies both lane vectors by one binomial each
// depends on cmn_pkg
module cmn_factor_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           valid_in,
    input  cmn_pkg::ctl_t  ctl_in,
    input  cmn_pkg::vec_t  vx_in,
    input  cmn_pkg::vec_t  vy_in,
    input  cmn_pkg::binom_t bx,
    input  cmn_pkg::binom_t by,
    output logic           valid_out,
    output cmn_pkg::ctl_t  ctl_out,
    output cmn_pkg::vec_t  vx_out,
    output cmn_pkg::vec_t  vy_out
);

    logic          valid_reg;
    cmn_pkg::ctl_t ctl_reg;
    cmn_pkg::vec_t vx_reg;
    cmn_pkg::vec_t vy_reg;
    cmn_pkg::vec_t vx_next;
    cmn_pkg::vec_t vy_next;

    assign vx_next = cmn_pkg::binom_mul(vx_in, bx.e_var, bx.e_fix);
    assign vy_next = cmn_pkg::binom_mul(vy_in, by.e_var, by.e_fix);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= ctl_in;
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign vx_out    = vx_reg;
    assign vy_out    = vy_reg;

endmodule

// ===== hw/rtl/cmn_serializer.sv =====
// takes the two lane products, forms their difference and sends 32 coefficients
// with the squared norm, summed as they go, on the last one; depends on cmn_pkg
module cmn_serializer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cmn_pkg::vec_t                  vx_in,
    input  cmn_pkg::vec_t                  vy_in,
    input  logic                           ok_in,
    input  logic [cmn_pkg::NORM_W-1:0]     budget,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cmn_pkg::IDX_W-1:0]      m_coeff_index,
    output logic signed [cmn_pkg::COEF_W-1:0] m_coeff_value,
    output logic [cmn_pkg::NORM_W-1:0]     m_norm_sq,
    output logic                           m_within_budget,
    output logic                           m_admissible,
    output logic                           m_last
);

    logic                          busy_reg;
    logic [cmn_pkg::IDX_W-1:0]     idx_reg;
    logic [cmn_pkg::NORM_W-1:0]    acc_reg;
    logic                          ok_reg;
    cmn_pkg::vec_t                 data_reg;
    cmn_pkg::vec_t                 diff;

    logic                          m_valid_reg;
    logic [cmn_pkg::IDX_W-1:0]     index_reg;
    cmn_pkg::coef_t                value_reg;
    logic [cmn_pkg::NORM_W-1:0]    norm_reg;
    logic                          within_reg;
    logic                          adm_reg;
    logic                          last_reg;

    logic                          emit;
    logic                          final_beat;
    logic                          load;
    cmn_pkg::coef_t                cur;
    logic signed [2*cmn_pkg::COEF_W-1:0] sq;
    logic [cmn_pkg::NORM_W-1:0]    acc_next;

    always_comb begin
        for (int k = 0; k < cmn_pkg::NUM_COEFF; k++) begin
            diff[k] = cmn_pkg::coef_t'(vx_in[k]) - cmn_pkg::coef_t'(vy_in[k]);
        end
    end

    assign emit       = busy_reg && (!m_valid_reg || m_ready);
    assign final_beat = emit && (idx_reg == cmn_pkg::LAST_IDX);
    assign in_ready   = !busy_reg || final_beat;
    assign load       = in_valid && in_ready;

    assign cur      = data_reg[idx_reg];
    assign sq       = cur * cur;
    assign acc_next = acc_reg + sq[cmn_pkg::NORM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (final_beat) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= diff;
            ok_reg   <= ok_in;
            acc_reg  <= '0;
        end else if (emit) begin
            acc_reg <= acc_next;
        end
        if (emit) begin
            index_reg  <= idx_reg;
            value_reg  <= cur;
            last_reg   <= final_beat;
            norm_reg   <= final_beat ? acc_next : '0;
            within_reg <= final_beat && (acc_next <= budget);
            adm_reg    <= final_beat && ok_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_coeff_index   = index_reg;
    assign m_coeff_value   = value_reg;
    assign m_norm_sq       = norm_reg;
    assign m_within_budget = within_reg;
    assign m_admissible    = adm_reg;
    assign m_last          = last_reg;

endmodule

// ===== hw/rtl/cyclotomic_minor_norm.sv =====
// top level of the cyclotomic minor norm block: input stage, eight binomial stages
// and the output serializer; depends on cmn_pkg, cmn_factor_stage, cmn_serializer
//
// Each transaction on the s_ channel names two coset-union sets A and C and two
// points x and y. The block forms D = P_A(x)P_C(y) - P_A(y)P_C(x) in Z[zeta]/(zeta^32+1)
// and sends its 32 coefficients on the m_ channel as 32 transactions, index 0 first.
// The last one (m_last high) also carries the squared norm, the budget flag
// (norm <= norm_budget) and the admissibility flag; these read 0 on earlier beats.
// From the accepting edge to the first result an item passes the input register,
// which loads at the accepting edge, then eight binomial stages (one per coset
// factor, both products side by side), the serializer load and the output register.
// A new transaction is accepted every cycle while the pipeline has room; the output
// serializer limits sustained throughput: it emits one coefficient per cycle while
// m_ready allows, and loads the next item on the cycle it sends the last coefficient
// of the current one.
// cfg_wen writes norm_budget (reset value 939) at once; write it only while idle.
module cyclotomic_minor_norm (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [cmn_pkg::NORM_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_a_res8,
    input  logic [3:0]                     s_a_res4,
    input  logic [4:0]                     s_a_res2,
    input  logic [5:0]                     s_a_res1,
    input  logic [2:0]                     s_c_res8,
    input  logic [3:0]                     s_c_res4,
    input  logic [4:0]                     s_c_res2,
    input  logic [5:0]                     s_c_res1,
    input  logic [5:0]                     s_x_point,
    input  logic [5:0]                     s_y_point,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cmn_pkg::IDX_W-1:0]      m_coeff_index,
    output logic signed [cmn_pkg::COEF_W-1:0] m_coeff_value,
    output logic [cmn_pkg::NORM_W-1:0]     m_norm_sq,
    output logic                           m_within_budget,
    output logic                           m_admissible,
    output logic                           m_last
);

    // budget register
    logic [cmn_pkg::NORM_W-1:0] budget_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= cmn_pkg::BUDGET_RESET;
        end else if (cfg_wen) begin
            budget_reg <= cfg_wdata;
        end
    end

    // exponents of each binomial, all mod 64
    logic [5:0] ax8, ax4, ax2, ay8, ay4, ay2;
    logic [5:0] cx8, cx4, cx2, cy8, cy4, cy2;
    logic [5:0] ar8, ar4, ar2, cr8, cr4, cr2;

    assign ar8 = {s_a_res8, 3'b000};
    assign ar4 = {s_a_res4, 2'b00};
    assign ar2 = {s_a_res2, 1'b0};
    assign cr8 = {s_c_res8, 3'b000};
    assign cr4 = {s_c_res4, 2'b00};
    assign cr2 = {s_c_res2, 1'b0};
    assign ax8 = {s_x_point[2:0], 3'b000};
    assign ax4 = {s_x_point[3:0], 2'b00};
    assign ax2 = {s_x_point[4:0], 1'b0};
    assign ay8 = {s_y_point[2:0], 3'b000};
    assign ay4 = {s_y_point[3:0], 2'b00};
    assign ay2 = {s_y_point[4:0], 1'b0};
    assign cx8 = ax8;
    assign cx4 = ax4;
    assign cx2 = ax2;
    assign cy8 = ay8;
    assign cy4 = ay4;
    assign cy2 = ay2;

    // admissibility from membership masks of the eight cosets
    logic [63:0] ma8, ma4, ma2, ma1, mc8, mc4, mc2, mc1;
    logic [63:0] amask, cmask, both;
    logic        a_ok, c_ok, ok_in;

    assign ma8 = cmn_pkg::coset_member({3'b000, s_a_res8}, 6'b000111);
    assign ma4 = cmn_pkg::coset_member({2'b00, s_a_res4}, 6'b001111);
    assign ma2 = cmn_pkg::coset_member({1'b0, s_a_res2}, 6'b011111);
    assign ma1 = cmn_pkg::coset_member(s_a_res1, 6'b111111);
    assign mc8 = cmn_pkg::coset_member({3'b000, s_c_res8}, 6'b000111);
    assign mc4 = cmn_pkg::coset_member({2'b00, s_c_res4}, 6'b001111);
    assign mc2 = cmn_pkg::coset_member({1'b0, s_c_res2}, 6'b011111);
    assign mc1 = cmn_pkg::coset_member(s_c_res1, 6'b111111);

    assign a_ok = ~|((ma8 & ma4) | (ma8 & ma2) | (ma8 & ma1) |
                     (ma4 & ma2) | (ma4 & ma1) | (ma2 & ma1));
    assign c_ok = ~|((mc8 & mc4) | (mc8 & mc2) | (mc8 & mc1) |
                     (mc4 & mc2) | (mc4 & mc1) | (mc2 & mc1));
    assign amask = ma8 | ma4 | ma2 | ma1;
    assign cmask = mc8 | mc4 | mc2 | mc1;
    assign both  = amask | cmask;
    assign ok_in = a_ok && c_ok && !(|(amask & cmask)) &&
                   !both[s_x_point] && !both[s_y_point] && (s_x_point != s_y_point);

    // factor list: A's cosets then C's, lane x pairs A with x and C with y
    cmn_pkg::ctl_t ctl_in;

    always_comb begin
        ctl_in.ok       = ok_in;
        ctl_in.lx[0]    = '{e_var: ax8, e_fix: ar8};
        ctl_in.lx[1]    = '{e_var: ax4, e_fix: ar4};
        ctl_in.lx[2]    = '{e_var: ax2, e_fix: ar2};
        ctl_in.lx[3]    = '{e_var: s_x_point, e_fix: s_a_res1};
        ctl_in.lx[4]    = '{e_var: cy8, e_fix: cr8};
        ctl_in.lx[5]    = '{e_var: cy4, e_fix: cr4};
        ctl_in.lx[6]    = '{e_var: cy2, e_fix: cr2};
        ctl_in.lx[7]    = '{e_var: s_y_point, e_fix: s_c_res1};
        ctl_in.ly[0]    = '{e_var: ay8, e_fix: ar8};
        ctl_in.ly[1]    = '{e_var: ay4, e_fix: ar4};
        ctl_in.ly[2]    = '{e_var: ay2, e_fix: ar2};
        ctl_in.ly[3]    = '{e_var: s_y_point, e_fix: s_a_res1};
        ctl_in.ly[4]    = '{e_var: cx8, e_fix: cr8};
        ctl_in.ly[5]    = '{e_var: cx4, e_fix: cr4};
        ctl_in.ly[6]    = '{e_var: cx2, e_fix: cr2};
        ctl_in.ly[7]    = '{e_var: s_x_point, e_fix: s_c_res1};
    end

    // pipeline moves as one; it stalls only when its last stage cannot hand off
    logic          adv;
    logic          ser_ready;
    logic          valid_chain [cmn_pkg::NUM_FACTOR+1];
    cmn_pkg::ctl_t ctl_chain   [cmn_pkg::NUM_FACTOR+1];
    cmn_pkg::vec_t vx_chain    [cmn_pkg::NUM_FACTOR+1];
    cmn_pkg::vec_t vy_chain    [cmn_pkg::NUM_FACTOR+1];

    logic          in_valid_reg;
    cmn_pkg::ctl_t in_ctl_reg;

    assign adv     = !valid_chain[cmn_pkg::NUM_FACTOR] || ser_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_ctl_reg <= ctl_in;
        end
    end

    assign valid_chain[0] = in_valid_reg;
    assign ctl_chain[0]   = in_ctl_reg;
    assign vx_chain[0]    = cmn_pkg::VEC_ONE;
    assign vy_chain[0]    = cmn_pkg::VEC_ONE;

    for (genvar i = 0; i < cmn_pkg::NUM_FACTOR; i++) begin : g_factor
        cmn_factor_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .valid_in  (valid_chain[i]),
            .ctl_in    (ctl_chain[i]),
            .vx_in     (vx_chain[i]),
            .vy_in     (vy_chain[i]),
            .bx        (ctl_chain[i].lx[i]),
            .by        (ctl_chain[i].ly[i]),
            .valid_out (valid_chain[i+1]),
            .ctl_out   (ctl_chain[i+1]),
            .vx_out    (vx_chain[i+1]),
            .vy_out    (vy_chain[i+1])
        );
    end

    // difference and coefficient-by-coefficient output
    cmn_serializer u_ser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (valid_chain[cmn_pkg::NUM_FACTOR]),
        .in_ready        (ser_ready),
        .vx_in           (vx_chain[cmn_pkg::NUM_FACTOR]),
        .vy_in           (vy_chain[cmn_pkg::NUM_FACTOR]),
        .ok_in           (ctl_chain[cmn_pkg::NUM_FACTOR].ok),
        .budget          (budget_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_coeff_index   (m_coeff_index),
        .m_coeff_value   (m_coeff_value),
        .m_norm_sq       (m_norm_sq),
        .m_within_budget (m_within_budget),
        .m_admissible    (m_admissible),
        .m_last          (m_last)
    );

endmodule

// ===== tb/cmn_checker.sv =====
// checker of the cyclotomic minor norm block: predicts the 32 coefficient results of each
// accepted s_ transaction and compares them with the m_ channel; depends on cmn_pkg
module cmn_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [cmn_pkg::NORM_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [2:0]                        s_a_res8,
    input  logic [3:0]                        s_a_res4,
    input  logic [4:0]                        s_a_res2,
    input  logic [5:0]                        s_a_res1,
    input  logic [2:0]                        s_c_res8,
    input  logic [3:0]                        s_c_res4,
    input  logic [4:0]                        s_c_res2,
    input  logic [5:0]                        s_c_res1,
    input  logic [5:0]                        s_x_point,
    input  logic [5:0]                        s_y_point,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [cmn_pkg::IDX_W-1:0]         m_coeff_index,
    input  logic signed [cmn_pkg::COEF_W-1:0] m_coeff_value,
    input  logic [cmn_pkg::NORM_W-1:0]        m_norm_sq,
    input  logic                              m_within_budget,
    input  logic                              m_admissible,
    input  logic                              m_last,
    output int                                errors,
    output int                                pending
);

    typedef struct {
        logic [cmn_pkg::IDX_W-1:0]  idx;
        cmn_pkg::coef_t             value;
        logic [cmn_pkg::NORM_W-1:0] norm;
        logic                       wb;
        logic                       adm;
        logic                       last;
    } coeff_beat_t;

    coeff_beat_t                coeff_q[$];
    logic [cmn_pkg::NORM_W-1:0] budget_copy;
    int                         d_coef[cmn_pkg::NUM_COEFF];

    initial errors = 0;
    assign pending = coeff_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (at %0t)", what, got, want, $realtime);
        errors++;
    endtask

    // exponent of one of the 16 terms of P_S(t); bit f of sub picks the fixed residue
    function automatic logic [5:0] term_exp(input logic [3:0][5:0] res, input logic [5:0] t,
                                            input int sub);
        logic [5:0] e;
        e = 0;
        for (int f = 0; f < 4; f++)
            e += (((sub >> f) & 1) ? res[f] : t) << (3 - f);
        return e;
    endfunction

    function automatic logic [63:0] coset_bits(input int f, input logic [5:0] r);
        logic [63:0] m;
        int step;
        step = 64 >> (3 - f);
        for (int j = 0; j < 64; j++)
            m[j] = (j % step) == (r % step);
        return m;
    endfunction

    // fills d_coef with D folded onto zeta^0..zeta^31
    function automatic void minor_coeffs(input logic [3:0][5:0] ar, input logic [3:0][5:0] cr,
                                         input logic [5:0] x, input logic [5:0] y);
        logic [5:0] e;
        int s;
        for (int k = 0; k < cmn_pkg::NUM_COEFF; k++)
            d_coef[k] = 0;
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 16; j++) begin
                s = ($countones(i) + $countones(j)) % 2 ? -1 : 1;
                e = term_exp(ar, x, i) + term_exp(cr, y, j);
                d_coef[e[4:0]] += e[5] ? -s : s;
                e = term_exp(ar, y, i) + term_exp(cr, x, j);
                d_coef[e[4:0]] -= e[5] ? -s : s;
            end
        end
    endfunction

    function automatic logic set_admissible(input logic [3:0][5:0] ar,
                                            input logic [3:0][5:0] cr,
                                            input logic [5:0] x, input logic [5:0] y);
        logic [63:0] am, cm, m;
        logic ok;
        ok = (x != y);
        am = 0;
        cm = 0;
        for (int f = 0; f < 4; f++) begin
            m = coset_bits(f, ar[f]);
            if ((am & m) != 0) ok = 0;
            am |= m;
            m = coset_bits(f, cr[f]);
            if ((cm & m) != 0) ok = 0;
            cm |= m;
        end
        if ((am & cm) != 0) ok = 0;
        if ((am | cm) >> x & 1) ok = 0;
        if ((am | cm) >> y & 1) ok = 0;
        return ok;
    endfunction

    always @(posedge aclk) begin
        logic [3:0][5:0] ar, cr;
        coeff_beat_t b;
        coeff_beat_t w;
        int norm;
        logic ok;
        if (!aresetn) begin
            budget_copy <= cmn_pkg::BUDGET_RESET;
        end else begin
            if (cfg_wen) begin
                budget_copy <= cfg_wdata;
            end
            // prediction on each accepted input transaction
            if (s_valid && s_ready) begin
                ar = {s_a_res1, 1'b0, s_a_res2, 2'b0, s_a_res4, 3'b0, s_a_res8};
                cr = {s_c_res1, 1'b0, s_c_res2, 2'b0, s_c_res4, 3'b0, s_c_res8};
                minor_coeffs(ar, cr, s_x_point, s_y_point);
                ok = set_admissible(ar, cr, s_x_point, s_y_point);
                norm = 0;
                for (int k = 0; k < cmn_pkg::NUM_COEFF; k++)
                    norm += d_coef[k] * d_coef[k];
                for (int k = 0; k < cmn_pkg::NUM_COEFF; k++) begin
                    b.idx   = cmn_pkg::IDX_W'(k);
                    b.value = cmn_pkg::coef_t'(d_coef[k]);
                    b.last  = (k == cmn_pkg::NUM_COEFF - 1);
                    b.norm  = b.last ? cmn_pkg::NORM_W'(norm) : '0;
                    b.wb    = b.last && (norm <= budget_copy);
                    b.adm   = b.last && ok;
                    coeff_q = {coeff_q, b};
                end
            end
            if (m_valid && m_ready) begin
                if (coeff_q.size() == 0) begin
                    report("unexpected result, index", m_coeff_index, -1);
                end else begin
                    w = coeff_q.pop_front();
                    if (m_coeff_index != w.idx) report("coeff_index", m_coeff_index, w.idx);
                    if (m_coeff_value != w.value) report("coeff_value", m_coeff_value, w.value);
                    if (m_norm_sq != w.norm) report("norm_sq", m_norm_sq, w.norm);
                    if (m_within_budget != w.wb) report("within_budget", m_within_budget, w.wb);
                    if (m_admissible != w.adm) report("admissible", m_admissible, w.adm);
                    if (m_last != w.last) report("last", m_last, w.last);
                end
            end
        end
    end
endmodule

// ===== tb/tb_cyclotomic_minor_norm.sv =====
// testbench top of the cyclotomic minor norm block: clock, reset, stimulus and verdict
// depends on cmn_pkg, cyclotomic_minor_norm and cmn_checker
module tb_cyclotomic_minor_norm;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [2:0] a8;
        logic [3:0] a4;
        logic [4:0] a2;
        logic [5:0] a1;
        logic [2:0] c8;
        logic [3:0] c4;
        logic [4:0] c2;
        logic [5:0] c1;
        logic [5:0] x;
        logic [5:0] y;
    } set_pair_t;

    logic                       aclk = 0;
    logic                       aresetn = 0;
    logic                       cfg_wen = 0;
    logic [cmn_pkg::NORM_W-1:0] cfg_wdata = '0;
    logic                       s_valid = 0;
    logic                       s_ready;
    logic [2:0]                 s_a_res8 = '0;
    logic [3:0]                 s_a_res4 = '0;
    logic [4:0]                 s_a_res2 = '0;
    logic [5:0]                 s_a_res1 = '0;
    logic [2:0]                 s_c_res8 = '0;
    logic [3:0]                 s_c_res4 = '0;
    logic [4:0]                 s_c_res2 = '0;
    logic [5:0]                 s_c_res1 = '0;
    logic [5:0]                 s_x_point = '0;
    logic [5:0]                 s_y_point = '0;
    logic                       m_valid;
    logic                       m_ready = 0;
    logic [cmn_pkg::IDX_W-1:0]  m_coeff_index;
    cmn_pkg::coef_t             m_coeff_value;
    logic [cmn_pkg::NORM_W-1:0] m_norm_sq;
    logic                       m_within_budget;
    logic                       m_admissible;
    logic                       m_last;

    int errors;
    int pending;
    int send_idle = 34;  // percent of cycles the sender holds back
    int recv_idle = 68;  // percent of cycles the receiver stalls
    int quiet_cycles = 0;

    cyclotomic_minor_norm u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_res8(s_a_res8), .s_a_res4(s_a_res4), .s_a_res2(s_a_res2), .s_a_res1(s_a_res1),
        .s_c_res8(s_c_res8), .s_c_res4(s_c_res4), .s_c_res2(s_c_res2), .s_c_res1(s_c_res1),
        .s_x_point(s_x_point), .s_y_point(s_y_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_coeff_index(m_coeff_index), .m_coeff_value(m_coeff_value),
        .m_norm_sq(m_norm_sq), .m_within_budget(m_within_budget),
        .m_admissible(m_admissible), .m_last(m_last)
    );

    cmn_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_res8(s_a_res8), .s_a_res4(s_a_res4), .s_a_res2(s_a_res2), .s_a_res1(s_a_res1),
        .s_c_res8(s_c_res8), .s_c_res4(s_c_res4), .s_c_res2(s_c_res2), .s_c_res1(s_c_res1),
        .s_x_point(s_x_point), .s_y_point(s_y_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_coeff_index(m_coeff_index), .m_coeff_value(m_coeff_value),
        .m_norm_sq(m_norm_sq), .m_within_budget(m_within_budget),
        .m_admissible(m_admissible), .m_last(m_last),
        .errors(errors), .pending(pending)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // receiver backpressure, one decision per cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog: ends the run when no transaction moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one input transaction: optional sender gap, then hold valid until accepted
    task automatic send_pair(input set_pair_t p);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid   <= 1;
        s_a_res8  <= p.a8;
        s_a_res4  <= p.a4;
        s_a_res2  <= p.a2;
        s_a_res1  <= p.a1;
        s_c_res8  <= p.c8;
        s_c_res4  <= p.c4;
        s_c_res2  <= p.c2;
        s_c_res1  <= p.c1;
        s_x_point <= p.x;
        s_y_point <= p.y;
        // s_ready is sampled mid-cycle, the transaction then completes at the next edge
        forever begin
            @(negedge aclk);
            if (s_ready) break;
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    // let the pipeline drain before touching the budget register
    task automatic drain_and_write(input logic [cmn_pkg::NORM_W-1:0] value);
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (15) @(posedge aclk);
        cfg_wen   <= 1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 0;
    endtask

    // admissible by construction: A in residue classes pa,pb mod 8, C in pc,pd,
    // points in the four remaining classes
    function automatic set_pair_t well_formed();
        set_pair_t p;
        int cls[8];
        int t, k, b;
        for (int i = 0; i < 8; i++) cls[i] = i;
        for (int i = 7; i > 0; i--) begin
            k = $urandom_range(i);
            t = cls[i];
            cls[i] = cls[k];
            cls[k] = t;
        end
        b = $urandom_range(1);
        p.a8 = 3'(cls[0]);
        p.a4 = 4'(cls[1] + 8 * b);
        p.a2 = 5'(cls[1] + 8 * (1 - b) + 16 * $urandom_range(1));
        p.a1 = 6'(p.a2 + 32 * $urandom_range(1)) ^ 6'd16;
        b = $urandom_range(1);
        p.c8 = 3'(cls[2]);
        p.c4 = 4'(cls[3] + 8 * b);
        p.c2 = 5'(cls[3] + 8 * (1 - b) + 16 * $urandom_range(1));
        p.c1 = 6'(p.c2 + 32 * $urandom_range(1)) ^ 6'd16;
        p.x = 6'(cls[4 + $urandom_range(3)] + 8 * $urandom_range(7));
        do begin
            p.y = 6'(cls[4 + $urandom_range(3)] + 8 * $urandom_range(7));
        end while (p.y == p.x);
        return p;
    endfunction

    function automatic set_pair_t noise();
        set_pair_t p;
        p.a8 = 3'($urandom); p.a4 = 4'($urandom); p.a2 = 5'($urandom); p.a1 = 6'($urandom);
        p.c8 = 3'($urandom); p.c4 = 4'($urandom); p.c2 = 5'($urandom); p.c1 = 6'($urandom);
        p.x  = 6'($urandom); p.y  = 6'($urandom);
        return p;
    endfunction

    set_pair_t   dir_p;
    logic [18:0] budgets[6];

    initial begin
        budgets = '{19'd0, 19'd262144, 19'd1, 19'd939, 19'd0, 19'd0};
        budgets[4] = 19'($urandom_range(3000));
        budgets[5] = 19'($urandom_range(262144));
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part at the reset budget
        dir_p = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};          // all zero, points equal
        send_pair(dir_p);
        dir_p = '{7, 15, 31, 63, 7, 15, 31, 63, 63, 63};  // all ones
        send_pair(dir_p);
        dir_p = '{0, 1, 9, 25, 2, 3, 11, 27, 4, 5};       // admissible
        send_pair(dir_p);
        dir_p = '{0, 1, 9, 25, 2, 3, 11, 27, 4, 4};       // points equal only
        send_pair(dir_p);
        dir_p = '{0, 8, 9, 25, 2, 3, 11, 27, 4, 5};       // cosets of A overlap
        send_pair(dir_p);
        dir_p = '{0, 1, 9, 25, 0, 3, 11, 27, 4, 5};       // A and C overlap
        send_pair(dir_p);
        dir_p = '{0, 1, 9, 25, 2, 3, 11, 27, 8, 5};       // x inside A
        send_pair(dir_p);
        dir_p = '{0, 1, 9, 25, 2, 3, 11, 27, 4, 19};      // y inside C
        send_pair(dir_p);
        dir_p = '{7, 14, 30, 62, 5, 12, 28, 60, 0, 1};
        send_pair(dir_p);
        repeat (6) send_pair(well_formed());
        repeat (4) send_pair(noise());

        // random part: three idling regimes, two budget settings each
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_write(budgets[ph]);
            case (ph / 2)
                0: begin send_idle = 34; recv_idle = 68; end
                1: begin send_idle = 68; recv_idle = 34; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            repeat (58) begin
                if ($urandom_range(99) < 70) send_pair(well_formed());
                else send_pair(noise());
            end
        end

        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== cyclotomic_minor_norm.f =====
hw/rtl/cmn_pkg.sv
hw/rtl/cmn_factor_stage.sv
hw/rtl/cmn_serializer.sv
hw/rtl/cyclotomic_minor_norm.sv
tb/cmn_checker.sv
tb/tb_cyclotomic_minor_norm.sv
